/* sv/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

/* sv/ssr_pkg.sv */
// Types, widths and codes shared by the scissor rectangle block.
package ssr_pkg;
    localparam int FRAC_BITS = 16;
    localparam int NORM_BITS = 28;
    localparam int NW  = NORM_BITS;
    localparam int MW  = 2 * NORM_BITS + 2;   // product / magnitude width
    localparam int SW  = MW + 1;              // signed normal components
    localparam int QW  = 32;                  // quotient operand width
    localparam int PW  = 64;                  // multiplier product width
    localparam int VW  = FRAC_BITS + 3;       // signed bound width
    localparam int QLW = FRAC_BITS + 2;       // quotient magnitude width
    localparam int WW  = 16;                  // window / pixel width
    localparam int CW  = 31;                  // Q15.16 register width
    localparam int PXW = VW + WW;
    localparam int QDEPTH = 2;
    localparam int QPW = $clog2(QDEPTH);

    localparam logic signed [VW-1:0] V_ONE = VW'(1 << FRAC_BITS);
    localparam logic [QLW-1:0] Q_LIM = QLW'(2 << FRAC_BITS);

    typedef enum logic [2:0] {
        CFG_NEAR   = 3'd0,
        CFG_HALF_W = 3'd1,
        CFG_HALF_H = 3'd2,
        CFG_WIN_W  = 3'd3,
        CFG_WIN_H  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CW-1:0] npd;
        logic [CW-1:0] half_w;
        logic [CW-1:0] half_h;
        logic [WW-1:0] win_w;
        logic [WW-1:0] win_h;
    } t_cfg;

    // one axis after scaling to working precision
    typedef struct packed {
        logic          sa;
        logic [NW-1:0] ua;
        logic          sz;
        logic [NW-1:0] uz;
        logic [NW-1:0] ur;
        logic          skip;
    } t_axis_in;

    typedef struct packed {
        t_axis_in ax;
        t_axis_in ay;
    } t_item;

    typedef struct packed {
        logic idle;
        logic done;
    } t_axis_stat;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ_A, S_SQ_Z, S_SQ_R, S_DISC, S_SQRT,
        S_P_ZQ, S_P_RA, S_P_AQ, S_P_RZ, S_RZ,
        S_ROOT, S_QNORM, S_QMA, S_QMB, S_QCMP, S_QDIV, S_QUPD,
        S_NEXT, S_DONE
    } t_axis_state;
endpackage

/* sv/ssr_front.sv */
// Input stage: takes a sphere beat and scales each axis to working precision.
module ssr_front import ssr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic signed [31:0] i_center_z,
    input  logic [30:0]        i_sphere_radius,
    output logic               o_q_push,
    input  logic               i_q_full,
    output t_item              o_q_item
);
    logic               r_vld;
    logic               n_vld;
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [30:0]        r_rad;
    logic               w_acc;

    function automatic t_axis_in norm_axis(logic signed [31:0] a, logic signed [31:0] z,
                                           logic [30:0] r);
        logic [31:0] ua, uz, ur, m;
        logic [5:0]  n, sh;
        t_axis_in    o;
        ua = a[31] ? 32'(-a) : 32'(a);
        uz = z[31] ? 32'(-z) : 32'(z);
        ur = {1'b0, r};
        m  = (ua > uz) ? ua : uz;
        if (ur > m) m = ur;
        n = '0;
        for (int i = 0; i < 32; i++) begin
            if (m[i]) n = 6'(i + 1);
        end
        if (n > 6'(NW)) begin
            sh   = n - 6'(NW);
            o.ua = NW'(ua >> sh);
            o.uz = NW'(uz >> sh);
            o.ur = NW'(ur >> sh);
        end else begin
            sh   = 6'(NW) - n;
            o.ua = NW'(ua << sh);
            o.uz = NW'(uz << sh);
            o.ur = NW'(ur << sh);
        end
        o.sa   = a[31];
        o.sz   = z[31];
        o.skip = (m == '0) || (o.uz == '0);
        return o;
    endfunction

    assign full     = r_vld && i_q_full;
    assign w_acc    = push && !full;
    assign o_q_push = r_vld && !i_q_full;
    assign n_vld    = w_acc || (r_vld && !o_q_push);

    assign o_q_item.ax = norm_axis(r_cx, r_cz, r_rad);
    assign o_q_item.ay = norm_axis(r_cy, r_cz, r_rad);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cx  <= i_center_x;
            r_cy  <= i_center_y;
            r_cz  <= i_center_z;
            r_rad <= i_sphere_radius;
        end
    end
endmodule

/* sv/ssr_fifo.sv */
// Short queue of scaled items between the input stage and the solvers.
module ssr_fifo import ssr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);
    t_item            r_mem [QDEPTH];
    logic [QPW-1:0]   r_wp, r_rp;
    logic [QPW:0]     r_cnt;
    logic             w_wr, w_rd;

    assign o_full  = (r_cnt == (QPW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= (r_wp == QPW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (w_rd) r_rp <= (r_rp == QPW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (QPW+1)'(w_wr) - (QPW+1)'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_item;
    end
endmodule

/* sv/ssr_axis.sv */
// Per-axis tangent solver: shared multiplier, serial root, restoring divider.
`include "assert_macros.svh"
module ssr_axis import ssr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_axis_in             i_item,
    input  logic                 i_ack,
    input  logic [CW-1:0]        i_npd,
    input  logic [CW-1:0]        i_half,
    output t_axis_stat           o_stat,
    output logic signed [VW-1:0] o_low,
    output logic signed [VW-1:0] o_high
);
    t_axis_state          r_state, n_state;
    t_axis_in             r_in;
    logic [PW-1:0]        r_prod;
    logic [QW-1:0]        w_ma, w_mb;
    logic [MW-1:0]        r_l2, r_d, r_bit, r_res;
    logic [MW-1:0]        r_zq, r_ra, r_aq, r_rz, r_un, r_ud;
    logic [5:0]           r_cnt;
    logic                 r_k, r_neg, r_nxpos;
    logic [PW-1:0]        r_ta, r_tb;
    logic [PW:0]          r_rem;
    logic [QLW-1:0]       r_q;
    logic signed [VW-1:0] r_low, r_high;

    logic signed [SW-1:0] w_ra_s, w_rz_s, w_aq_s, w_zq_s, w_nx, w_nz;
    logic                 w_front, w_take, w_zero, w_sq_ge, w_big8, w_big1, w_sat;
    logic [MW-1:0]        w_un, w_ud, w_sq_sum, w_or;
    logic [PW:0]          w_rem_sh;
    logic                 w_dbit;
    logic signed [VW-1:0] w_v;

    // root terms with signs applied
    assign w_ra_s = r_in.sa ? -$signed({1'b0, r_ra}) : $signed({1'b0, r_ra});
    assign w_rz_s = r_in.sz ? -$signed({1'b0, r_rz}) : $signed({1'b0, r_rz});
    assign w_aq_s = (r_in.sa ^ r_in.sz) ? -$signed({1'b0, r_aq}) : $signed({1'b0, r_aq});
    assign w_zq_s = $signed({1'b0, r_zq});
    assign w_nx   = r_k ? (w_ra_s - w_zq_s) : (w_ra_s + w_zq_s);
    assign w_nz   = r_k ? (w_rz_s + w_aq_s) : (w_rz_s - w_aq_s);
    // tangency depth equals +/- nx, so in-front reduces to a sign test on nx
    assign w_front = (w_nx != '0) && ((!w_nx[SW-1]) == (r_in.sz ^ r_k));
    assign w_take  = w_front && (r_in.ur != '0);
    assign w_un    = w_nz[SW-1] ? MW'(-w_nz) : MW'(w_nz);
    assign w_ud    = w_nx[SW-1] ? MW'(-w_nx) : MW'(w_nx);
    assign w_zero  = (w_un == '0) || (i_npd == '0);

    assign w_sq_sum = r_res + r_bit;
    assign w_sq_ge  = (r_d >= w_sq_sum);

    assign w_or   = r_un | r_ud;
    assign w_big8 = (w_or >> (QW + 8)) != '0;
    assign w_big1 = (w_or >> QW) != '0;

    assign w_sat    = (r_prod == '0) || ({1'b0, r_ta} >= {r_prod, 1'b0});
    assign w_rem_sh = (r_cnt == '0) ? r_rem : (r_rem << 1);
    assign w_dbit   = (w_rem_sh >= {1'b0, r_tb});
    assign w_v      = r_neg ? -$signed(VW'(r_q)) : $signed(VW'(r_q));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_start) n_state = i_item.skip ? S_DONE : S_SQ_A;
            S_SQ_A:  n_state = S_SQ_Z;
            S_SQ_Z:  n_state = S_SQ_R;
            S_SQ_R:  n_state = S_DISC;
            S_DISC:  n_state = (r_l2 <= MW'(r_prod)) ? S_DONE : S_SQRT;
            S_SQRT:  if (r_cnt == 6'(NW)) n_state = S_P_ZQ;
            S_P_ZQ:  n_state = S_P_RA;
            S_P_RA:  n_state = S_P_AQ;
            S_P_AQ:  n_state = S_P_RZ;
            S_P_RZ:  n_state = S_RZ;
            S_RZ:    n_state = S_ROOT;
            S_ROOT: begin
                if (!w_take) n_state = S_NEXT;
                else if (w_zero) n_state = (i_half == '0) ? S_NEXT : S_QUPD;
                else n_state = S_QNORM;
            end
            S_QNORM: if (!w_big8 && !w_big1) n_state = S_QMA;
            S_QMA:   n_state = S_QMB;
            S_QMB:   n_state = S_QCMP;
            S_QCMP:  n_state = w_sat ? S_QUPD : S_QDIV;
            S_QDIV:  if (r_cnt == 6'(FRAC_BITS)) n_state = S_QUPD;
            S_QUPD:  n_state = S_NEXT;
            S_NEXT:  n_state = r_k ? S_DONE : S_ROOT;
            S_DONE:  if (i_ack) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_SQ_A:  begin w_ma = QW'(r_in.ua); w_mb = QW'(r_in.ua); end
            S_SQ_Z:  begin w_ma = QW'(r_in.uz); w_mb = QW'(r_in.uz); end
            S_SQ_R:  begin w_ma = QW'(r_in.ur); w_mb = QW'(r_in.ur); end
            S_P_ZQ:  begin w_ma = QW'(r_in.uz); w_mb = QW'(r_res); end
            S_P_RA:  begin w_ma = QW'(r_in.ur); w_mb = QW'(r_in.ua); end
            S_P_AQ:  begin w_ma = QW'(r_in.ua); w_mb = QW'(r_res); end
            S_P_RZ:  begin w_ma = QW'(r_in.ur); w_mb = QW'(r_in.uz); end
            S_QMA:   begin w_ma = QW'(r_un);    w_mb = QW'(i_npd); end
            S_QMB:   begin w_ma = QW'(r_ud);    w_mb = QW'(i_half); end
            default: begin w_ma = '0;           w_mb = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_in   <= i_item;
                    r_low  <= -V_ONE;
                    r_high <= V_ONE;
                    r_k    <= 1'b0;
                end
            end
            S_SQ_Z: r_l2 <= MW'(r_prod);
            S_SQ_R: r_l2 <= r_l2 + MW'(r_prod);
            S_DISC: begin
                r_d   <= r_l2 - MW'(r_prod);
                r_bit <= MW'(1) << (2 * NORM_BITS);
                r_res <= '0;
                r_cnt <= '0;
            end
            S_SQRT: begin
                if (w_sq_ge) begin
                    r_d   <= r_d - w_sq_sum;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
            end
            S_P_RA: r_zq <= MW'(r_prod);
            S_P_AQ: r_ra <= MW'(r_prod);
            S_P_RZ: r_aq <= MW'(r_prod);
            S_RZ:   r_rz <= MW'(r_prod);
            S_ROOT: begin
                r_un    <= w_un;
                r_ud    <= w_ud;
                r_neg   <= w_nz[SW-1] ^ w_nx[SW-1];
                r_nxpos <= !w_nx[SW-1];
                r_q     <= '0;
            end
            S_QNORM: begin
                if (w_big8) begin
                    r_un <= r_un >> 8;
                    r_ud <= r_ud >> 8;
                end else if (w_big1) begin
                    r_un <= r_un >> 1;
                    r_ud <= r_ud >> 1;
                end
            end
            S_QCMP: begin
                r_ta  <= r_prod;
                r_tb  <= r_prod;
                r_rem <= {1'b0, r_ta};
                r_cnt <= '0;
                r_q   <= w_sat ? Q_LIM : '0;
            end
            S_QMB: r_ta <= r_prod;
            S_QDIV: begin
                r_rem <= w_dbit ? (w_rem_sh - {1'b0, r_tb}) : w_rem_sh;
                r_q   <= {r_q[QLW-2:0], w_dbit};
                r_cnt <= r_cnt + 1'b1;
            end
            S_QUPD: begin
                if (r_nxpos && (w_v > r_low))   r_low  <= w_v;
                if (!r_nxpos && (w_v < r_high)) r_high <= w_v;
            end
            S_NEXT: r_k <= 1'b1;
            default: ;
        endcase
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_low  = r_low;
    assign o_high = r_high;

    `ASSERT_CLK(a_start_idle, i_clk, i_rst_n, i_start |-> (r_state == S_IDLE))
    `ASSERT_NEVER(a_div_zero, i_clk, i_rst_n, (r_state == S_QDIV) && (r_tb == '0))
    `ASSERT_CLK(a_done_hold, i_clk, i_rst_n, (r_state == S_DONE) && !i_ack |=> $stable(r_low) && $stable(r_high))
endmodule

/* sv/ssr_back.sv */
// Back end: runs both axis solvers, maps bounds to pixels, holds the result.
`include "assert_macros.svh"
module ssr_back import ssr_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  t_item         i_q_item,
    output logic          o_q_pop,
    input  t_cfg          i_cfg,
    output logic          empty,
    input  logic          pop,
    output logic [WW-1:0] o_rect_x,
    output logic [WW-1:0] o_rect_y,
    output logic [WW-1:0] o_rect_width,
    output logic [WW-1:0] o_rect_height
);
    t_axis_stat           w_sx, w_sy;
    logic signed [VW-1:0] w_xl, w_xh, w_yl, w_yh;
    logic                 w_start, w_ack;
    logic                 r_out_vld;
    logic [WW-1:0]        w_x1, w_x2, w_y1, w_y2;
    logic [WW-1:0]        r_x, r_y, r_w, r_h;

    function automatic logic [WW-1:0] to_pixel(logic signed [VW-1:0] b, logic [WW-1:0] win);
        logic signed [VW:0] v;
        logic [PXW-1:0]     p;
        v = $signed({b[VW-1], b}) + $signed((VW+1)'(1 << FRAC_BITS));
        if (v <= 0) return '0;
        p = (PXW'(v[VW-1:0]) * PXW'(win)) >> (FRAC_BITS + 1);
        if (p > PXW'(win)) return win;
        return WW'(p);
    endfunction

    assign w_start = !i_q_empty && w_sx.idle && w_sy.idle;
    assign o_q_pop = w_start;
    assign w_ack   = w_sx.done && w_sy.done && (!r_out_vld || pop);

    ssr_axis u_axis_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_item  (i_q_item.ax),
        .i_ack   (w_ack),
        .i_npd   (i_cfg.npd),
        .i_half  (i_cfg.half_w),
        .o_stat  (w_sx),
        .o_low   (w_xl),
        .o_high  (w_xh)
    );

    ssr_axis u_axis_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_item  (i_q_item.ay),
        .i_ack   (w_ack),
        .i_npd   (i_cfg.npd),
        .i_half  (i_cfg.half_h),
        .o_stat  (w_sy),
        .o_low   (w_yl),
        .o_high  (w_yh)
    );

    assign w_x1 = to_pixel(w_xl, i_cfg.win_w);
    assign w_x2 = to_pixel(w_xh, i_cfg.win_w);
    assign w_y1 = to_pixel(w_yl, i_cfg.win_h);
    assign w_y2 = to_pixel(w_yh, i_cfg.win_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_ack) begin
            r_out_vld <= 1'b1;
        end else if (pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ack) begin
            r_x <= w_x1;
            r_y <= w_y1;
            r_w <= (w_x2 > w_x1) ? (w_x2 - w_x1) : '0;
            r_h <= (w_y2 > w_y1) ? (w_y2 - w_y1) : '0;
        end
    end

    assign empty         = !r_out_vld;
    assign o_rect_x      = r_x;
    assign o_rect_y      = r_y;
    assign o_rect_width  = r_w;
    assign o_rect_height = r_h;

    // both solvers start together, so they must leave idle together
    `ASSERT_CLK(a_lockstep, i_clk, i_rst_n, w_sx.idle == w_sy.idle)
    `ASSERT_CLK(a_pop_nonempty, i_clk, i_rst_n, o_q_pop |-> !i_q_empty)
    `ASSERT_CLK(a_ack_slot, i_clk, i_rst_n, w_ack && r_out_vld |-> pop)
endmodule

/* sv/sphere_scissor_rect_top.sv */
// Top level of the light sphere scissor rectangle block.
// Input channel: push/full. A beat (center x/y/z signed Q16.16, radius
// unsigned Q15.16) is taken when push is high and full is low.
// Result channel: empty/pop. While empty is low the oldest rectangle
// (x, y, width, height in pixels) is on the rect ports; it is taken when
// pop is high. A stalled result holds, and up to four further spheres
// are still taken (solvers, input register, two-entry queue).
// Config channel: cfg_valid/cfg_ready, ready always high; index selects
// near distance, half width, half height, window width, window height.
// Write it only while the block is idle.
// Solvers: an axis that is skipped goes straight to done, and a solved
// axis can use the divider only for a root that it takes. The x and y
// axes run in parallel units, each with one shared multiplier, a serial
// square root and a restoring divider shared by both roots. The solvers
// take the next sphere from the queue only after both axes are done and
// their result has been taken into the output register.
// Reset (synchronous, active low) empties all queues and loads default
// register values: near 1.0, halves 1.0, window 1024 by 768.
module sphere_scissor_rect_top import ssr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic signed [31:0] i_center_z,
    input  logic [30:0]        i_sphere_radius,
    output logic               empty,
    input  logic               pop,
    output logic [15:0]        o_rect_x,
    output logic [15:0]        o_rect_y,
    output logic [15:0]        o_rect_width,
    output logic [15:0]        o_rect_height,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data
);
    t_cfg  r_cfg;
    logic  w_f_push, w_q_full, w_q_empty, w_q_pop;
    t_item w_f_item, w_q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.npd    <= CW'(65536);
            r_cfg.half_w <= CW'(65536);
            r_cfg.half_h <= CW'(65536);
            r_cfg.win_w  <= WW'(1024);
            r_cfg.win_h  <= WW'(768);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_NEAR:   r_cfg.npd    <= i_cfg_data;
                CFG_HALF_W: r_cfg.half_w <= i_cfg_data;
                CFG_HALF_H: r_cfg.half_h <= i_cfg_data;
                CFG_WIN_W:  r_cfg.win_w  <= i_cfg_data[WW-1:0];
                CFG_WIN_H:  r_cfg.win_h  <= i_cfg_data[WW-1:0];
                default: ;
            endcase
        end
    end

    ssr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_center_z      (i_center_z),
        .i_sphere_radius (i_sphere_radius),
        .o_q_push        (w_f_push),
        .i_q_full        (w_q_full),
        .o_q_item        (w_f_item)
    );

    ssr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_push),
        .i_item  (w_f_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_item  (w_q_item)
    );

    ssr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_q_empty),
        .i_q_item      (w_q_item),
        .o_q_pop       (w_q_pop),
        .i_cfg         (r_cfg),
        .empty         (empty),
        .pop           (pop),
        .o_rect_x      (o_rect_x),
        .o_rect_y      (o_rect_y),
        .o_rect_width  (o_rect_width),
        .o_rect_height (o_rect_height)
    );
endmodule
